// File: rtl/core/mgbb_pkg.sv
`timescale 1ns / 1ps
// Package for the mono glyph bit blitter.
// Holds item kinds, status codes, register indexes, store geometry and the glyph setup struct.
package mgbb_pkg;

   // Store geometry: widest screen in pixels and tallest screen in rows
   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 256;
   localparam int MAX_GLYPH   = 64;
   localparam int STORE_BYTES = (MAX_WIDTH / 8) * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   // Item kinds
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_GLYPH = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_WIDE = 2'd1;
   localparam logic [1:0] STATUS_TOO_TALL = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

   // Decoded start of a glyph
   typedef struct packed {
      logic [1:0]        status;
      logic              go;
      logic [2:0]        shift;
      logic [3:0]        bytes_per_row;
      logic [7:0]        edge_mask;
      logic              spill;
      logic [ADDR_W-1:0] row_base;
   } setup_type;

endpackage

// File: rtl/core/mgbb_glyph_setup.sv
`timescale 1ns / 1ps
// Glyph start decode: bounds checks, row layout and first row address.
// Depends on mgbb_pkg.
module mgbb_glyph_setup (
   input  logic [8:0]          pos_x,
   input  logic [7:0]          pos_y,
   input  logic [6:0]          glyph_width,
   input  logic [6:0]          glyph_height,
   input  logic [9:0]          screen_width,
   input  logic [8:0]          screen_height,
   output mgbb_pkg::setup_type setup
);
   import mgbb_pkg::*;

   logic [9:0]  width_sum;
   logic [9:0]  height_sum;
   logic [2:0]  part;
   logic [3:0]  merge_span;
   logic [14:0] row_offset;
   logic [15:0] base_sum;

   // Check the glyph against the screen, width first
   always_comb begin
      width_sum  = 10'(glyph_width) + 10'(pos_x);
      height_sum = 10'(glyph_height) + 10'(pos_y);
      if (width_sum >= screen_width || 32'(glyph_width) > MAX_GLYPH) begin
         setup.status = STATUS_TOO_WIDE;
      end else if (height_sum >= 10'(screen_height) || 32'(glyph_height) > MAX_GLYPH) begin
         setup.status = STATUS_TOO_TALL;
      end else begin
         setup.status = STATUS_OK;
      end
      setup.go = (setup.status == STATUS_OK) && (glyph_width != 7'd0) &&
                 (glyph_height != 7'd0);

      // Work out bytes per row, right edge fill and spill into one more byte
      setup.shift         = pos_x[2:0];
      part                = glyph_width[2:0];
      merge_span          = 4'(part) + 4'(pos_x[2:0]);
      setup.bytes_per_row = 4'(glyph_width[6:3]);
      setup.edge_mask     = 8'h00;
      setup.spill         = 1'b0;
      if (part != 3'd0) begin
         if (merge_span > 4'd8) begin
            merge_span  = merge_span - 4'd8;
            setup.spill = 1'b1;
         end
         setup.edge_mask     = (merge_span < 4'd8) ? (8'hFF >> merge_span) : 8'h00;
         setup.bytes_per_row = setup.bytes_per_row + 4'd1;
      end else if (pos_x[2:0] != 3'd0) begin
         setup.spill     = 1'b1;
         setup.edge_mask = 8'hFF >> pos_x[2:0];
      end

      // First row address, wrapped to the store size
      row_offset     = 15'(pos_y) * 15'(screen_width[9:3]);
      base_sum       = 16'(pos_x[8:3]) + 16'(row_offset);
      setup.row_base = base_sum[ADDR_W-1:0];
   end

endmodule

// File: rtl/core/mono_glyph_bit_blitter_unit.sv
`timescale 1ns / 1ps
// Mono glyph bit blitter: one-bit-per-pixel frame store with a glyph blitter.
// Depends on mgbb_pkg and mgbb_glyph_setup.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   req_     | req_valid / req_stall   | kind, pos_x, pos_y, glyph size, byte, addr
//   rsp_     | rsp_valid / rsp_stall   | status, read_data
//   csr_     | csr_valid / csr_ready   | csr_index, csr_wdata
//
// The single-port frame store takes one access per cycle. A glyph byte
// ending a row also writes its spill byte, if any, and then reads the next
// row's first byte; a good start reads the first row's byte, a clear sweeps
// every byte. After reset a clearing pass fills the store with 0xFF; items
// are held off meanwhile, configuration writes are taken.
// A waiting result does not stop work on the next item; a finished item
// waits in place only while the previous result is still stalled.
module mono_glyph_bit_blitter_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [6:0]  req_glyph_width,
   input  logic [6:0]  req_glyph_height,
   input  logic [7:0]  req_glyph_byte,
   input  logic [13:0] req_read_address,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_read_data,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import mgbb_pkg::*;

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_RDISS  = 3'd3;
   localparam logic [2:0] ST_RDCAP  = 3'd4;
   localparam logic [2:0] ST_GWRITE = 3'd5;
   localparam logic [2:0] ST_GSPILL = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [9:0]        screen_width_ff;
   logic [8:0]        screen_height_ff;

   // latched item fields
   logic [1:0]        kind_ff, kind_in;
   logic [8:0]        pos_x_ff, pos_x_in;
   logic [7:0]        pos_y_ff, pos_y_in;
   logic [6:0]        glyph_width_ff, glyph_width_in;
   logic [6:0]        glyph_height_ff, glyph_height_in;
   logic [7:0]        glyph_byte_ff, glyph_byte_in;
   logic [ADDR_W-1:0] read_address_ff, read_address_in;

   // glyph state
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [3:0]        column_count_ff, column_count_in;
   logic [7:0]        carry_bits_ff, carry_bits_in;
   logic [2:0]        bit_shift_ff, bit_shift_in;
   logic [3:0]        bytes_per_row_ff, bytes_per_row_in;
   logic [7:0]        edge_mask_ff, edge_mask_in;
   logic              spill_byte_ff, spill_byte_in;
   logic              glyph_armed_ff, glyph_armed_in;
   logic [6:0]        rows_left_ff, rows_left_in;
   logic [ADDR_W-1:0] last_addr_ff, last_addr_in;

   // clearing pass
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_reply_ff, clr_reply_in;

   // pending result
   logic [1:0]        status_ff, status_in;
   logic [7:0]        data_ff, data_in;

   // response register
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [7:0]        rsp_read_data_ff;

   // frame store
   logic [7:0]        store_mem [STORE_BYTES];
   logic [7:0]        mem_rdata_ff;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata;

   setup_type         setup;
   logic              done_now;
   logic              load_rsp;
   logic              rsp_free;
   logic [1:0]        res_status;
   logic [7:0]        res_data;
   logic [ADDR_W-1:0] glyph_addr;
   logic [15:0]       shifted;
   logic [7:0]        left_keep;
   logic              row_end;

   mgbb_glyph_setup u_setup (
      .pos_x         (pos_x_ff),
      .pos_y         (pos_y_ff),
      .glyph_width   (glyph_width_ff),
      .glyph_height  (glyph_height_ff),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .setup         (setup)
   );

   // Glyph byte datapath
   always_comb begin
      glyph_addr = row_base_ff + ADDR_W'(column_count_ff);
      shifted    = {glyph_byte_ff, 8'h00} >> bit_shift_ff;
      left_keep  = ~(8'hFF >> bit_shift_ff);
      row_end    = (5'(column_count_ff) + 5'd1) >= 5'(bytes_per_row_ff);
   end

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Sequencer: one store access per cycle, reads issued after all writes
   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      pos_x_in         = pos_x_ff;
      pos_y_in         = pos_y_ff;
      glyph_width_in   = glyph_width_ff;
      glyph_height_in  = glyph_height_ff;
      glyph_byte_in    = glyph_byte_ff;
      read_address_in  = read_address_ff;
      row_base_in      = row_base_ff;
      column_count_in  = column_count_ff;
      carry_bits_in    = carry_bits_ff;
      bit_shift_in     = bit_shift_ff;
      bytes_per_row_in = bytes_per_row_ff;
      edge_mask_in     = edge_mask_ff;
      spill_byte_in    = spill_byte_ff;
      glyph_armed_in   = glyph_armed_ff;
      rows_left_in     = rows_left_ff;
      last_addr_in     = last_addr_ff;
      clr_cnt_in       = clr_cnt_ff;
      clr_reply_in     = clr_reply_ff;
      status_in        = status_ff;
      data_in          = data_ff;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_addr         = clr_cnt_ff;
      mem_wdata        = 8'hFF;
      done_now         = 1'b0;
      load_rsp         = 1'b0;
      res_status       = status_ff;
      res_data         = data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in         = req_kind;
               pos_x_in        = req_pos_x;
               pos_y_in        = req_pos_y;
               glyph_width_in  = req_glyph_width;
               glyph_height_in = req_glyph_height;
               glyph_byte_in   = req_glyph_byte;
               read_address_in = req_read_address[ADDR_W-1:0];
               status_in       = STATUS_OK;
               data_in         = 8'h00;
               unique case (req_kind)
                  KIND_CLEAR: begin
                     state_in     = ST_CLEAR;
                     clr_cnt_in   = '0;
                     clr_reply_in = 1'b1;
                  end
                  KIND_START: state_in = ST_START;
                  KIND_GLYPH: state_in = glyph_armed_ff ? ST_GWRITE : ST_RESULT;
                  KIND_READ:  state_in = ST_RDISS;
               endcase
            end
         end
         ST_CLEAR: begin
            // sweep the store with white, one byte a cycle
            mem_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (&clr_cnt_ff) begin
               clr_reply_in = 1'b0;
               if (clr_reply_ff) begin
                  done_now = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_START: begin
            // take the decoded start; a rejected or empty glyph disarms
            status_in      = setup.status;
            res_status     = setup.status;
            glyph_armed_in = setup.go;
            if (setup.go) begin
               bit_shift_in     = setup.shift;
               bytes_per_row_in = setup.bytes_per_row;
               edge_mask_in     = setup.edge_mask;
               spill_byte_in    = setup.spill;
               row_base_in      = setup.row_base;
               column_count_in  = 4'd0;
               rows_left_in     = glyph_height_ff;
               state_in         = ST_RDISS;
            end else begin
               done_now = 1'b1;
            end
         end
         ST_RDISS: begin
            mem_re   = 1'b1;
            mem_addr = (kind_ff == KIND_READ) ? read_address_ff : row_base_ff;
            state_in = ST_RDCAP;
         end
         ST_RDCAP: begin
            // read data returns the byte; otherwise it seeds the row carry
            if (kind_ff == KIND_READ) begin
               res_data = mem_rdata_ff;
            end else begin
               carry_bits_in = left_keep & mem_rdata_ff;
            end
            done_now = 1'b1;
         end
         ST_GWRITE: begin
            mem_we   = 1'b1;
            mem_addr = glyph_addr;
            if (bit_shift_ff == 3'd0) begin
               mem_wdata = glyph_byte_ff;
            end else begin
               mem_wdata     = shifted[15:8] | carry_bits_ff;
               carry_bits_in = shifted[7:0];
            end
            if (row_end) begin
               if (!spill_byte_ff) begin
                  mem_wdata = mem_wdata | edge_mask_ff;
               end
               last_addr_in    = glyph_addr;
               row_base_in     = row_base_ff + ADDR_W'(screen_width_ff[9:3]);
               column_count_in = 4'd0;
               rows_left_in    = rows_left_ff - 7'd1;
               if (rows_left_ff == 7'd1) begin
                  glyph_armed_in = 1'b0;
               end
               state_in = spill_byte_ff ? ST_GSPILL : ST_RDISS;
            end else begin
               column_count_in = column_count_ff + 4'd1;
               done_now        = 1'b1;
            end
         end
         ST_GSPILL: begin
            // carried bits land in the next byte, white to their right
            mem_we    = 1'b1;
            mem_addr  = last_addr_ff + ADDR_W'(1);
            mem_wdata = carry_bits_ff | edge_mask_ff;
            state_in  = ST_RDISS;
         end
         ST_RESULT: begin
            done_now = 1'b1;
         end
      endcase

      // Hand the result over, or hold it until the response slot frees
      if (done_now) begin
         if (rsp_free) begin
            load_rsp = 1'b1;
            state_in = ST_IDLE;
         end else begin
            state_in  = ST_RESULT;
            status_in = res_status;
            data_in   = res_data;
         end
      end
   end

   // Control and glyph state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_cnt_ff       <= '0;
         clr_reply_ff     <= 1'b0;
         glyph_armed_ff   <= 1'b0;
         row_base_ff      <= '0;
         column_count_ff  <= 4'd0;
         carry_bits_ff    <= 8'h00;
         bit_shift_ff     <= 3'd0;
         bytes_per_row_ff <= 4'd0;
         edge_mask_ff     <= 8'h00;
         spill_byte_ff    <= 1'b0;
         rows_left_ff     <= 7'd0;
      end else begin
         state_ff         <= state_in;
         clr_cnt_ff       <= clr_cnt_in;
         clr_reply_ff     <= clr_reply_in;
         glyph_armed_ff   <= glyph_armed_in;
         row_base_ff      <= row_base_in;
         column_count_ff  <= column_count_in;
         carry_bits_ff    <= carry_bits_in;
         bit_shift_ff     <= bit_shift_in;
         bytes_per_row_ff <= bytes_per_row_in;
         edge_mask_ff     <= edge_mask_in;
         spill_byte_ff    <= spill_byte_in;
         rows_left_ff     <= rows_left_in;
      end
   end

   // Item fields and pending result
   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      pos_x_ff        <= pos_x_in;
      pos_y_ff        <= pos_y_in;
      glyph_width_ff  <= glyph_width_in;
      glyph_height_ff <= glyph_height_in;
      glyph_byte_ff   <= glyph_byte_in;
      read_address_ff <= read_address_in;
      last_addr_ff    <= last_addr_in;
      status_ff       <= status_in;
      data_ff         <= data_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= 10'd264;
         screen_height_ff <= 9'd176;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_SCREEN_WIDTH) begin
            screen_width_ff <= csr_wdata;
         end else if (csr_index == REG_SCREEN_HEIGHT) begin
            screen_height_ff <= csr_wdata[8:0];
         end
      end
   end

   // Frame store: single port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end else if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_addr];
      end
   end

   // Response register: load on finish, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff    <= res_status;
         rsp_read_data_ff <= res_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_read_data_ff;

   // Checks
   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("frame store written while idle");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) != ST_IDLE)
      else $error("response raised without an item in progress");

   a_armed_layout: assert property (@(posedge clock) disable iff (reset)
      glyph_armed_ff |-> (bytes_per_row_ff != 4'd0 && bytes_per_row_ff <= 4'd8 &&
                          column_count_ff < bytes_per_row_ff))
      else $error("armed glyph with bad row layout");

   a_armed_rows: assert property (@(posedge clock) disable iff (reset)
      glyph_armed_ff |-> rows_left_ff != 7'd0)
      else $error("armed glyph with no rows left");

endmodule

// File: tb/tb_mono_glyph_bit_blitter_unit.sv
`timescale 1ns / 1ps
// Testbench for mono_glyph_bit_blitter_unit: directed and random glyph traffic,
// each result checked against an in-bench model of the frame store and blitter.
// Depends on mgbb_pkg and the mono_glyph_bit_blitter_unit RTL.
module tb_mono_glyph_bit_blitter_unit;
   import mgbb_pkg::*;

   // Configuration register indexes that the block ignores
   localparam logic [1:0] REG_UNUSED_2      = 2'd2;
   localparam logic [1:0] REG_UNUSED_3      = 2'd3;

   localparam int DRAIN_CYCLES = 32;
   localparam int LIMIT_NS     = 4_000_000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [8:0]  pos_x;
      logic [7:0]  pos_y;
      logic [6:0]  glyph_width;
      logic [6:0]  glyph_height;
      logic [7:0]  glyph_byte;
      logic [13:0] read_address;
   } blit_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_data;
   } blit_rsp_type;

   // DUT ports, all inputs known from time zero
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind         = KIND_READ;
   logic [8:0]  req_pos_x        = '0;
   logic [7:0]  req_pos_y        = '0;
   logic [6:0]  req_glyph_width  = '0;
   logic [6:0]  req_glyph_height = '0;
   logic [7:0]  req_glyph_byte   = '0;
   logic [13:0] req_read_address = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_read_data;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index        = REG_SCREEN_WIDTH;
   logic [9:0]  csr_wdata        = '0;

   // Model state: frame store, screen size and the armed glyph
   logic [7:0]  pix_store [STORE_BYTES];
   int unsigned scr_w, scr_h;
   int unsigned cur_row, col_idx, carry, shift_amt, row_bytes, right_fill, rows_to_go;
   bit          spills, armed;

   blit_rsp_type blit_result_q [$];
   int          mismatch_count  = 0;
   int          blit_items_done = 0;
   int          clears_left     = 6;
   int          send_idle_pct   = 0;
   int          rsp_stall_pct   = 0;

   mono_glyph_bit_blitter_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .req_glyph_byte   (req_glyph_byte),
      .req_read_address (req_read_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Blitter model
   // ------------------------------------------------------------------
   function automatic int unsigned wrap_store(input int unsigned a);
      return a % STORE_BYTES;
   endfunction

   // Destination pixels left of the glyph inside its first byte
   function automatic int unsigned dest_keep_mask();
      return (32'hFF << (8 - shift_amt)) & 32'hFF;
   endfunction

   function automatic void fill_white();
      foreach (pix_store[i]) pix_store[i] = 8'hFF;
   endfunction

   function automatic void model_reset();
      fill_white();
      scr_w      = 264;
      scr_h      = 176;
      cur_row    = 0;
      col_idx    = 0;
      carry      = 0;
      shift_amt  = 0;
      row_bytes  = 0;
      right_fill = 0;
      rows_to_go = 0;
      spills     = 1'b0;
      armed      = 1'b0;
   endfunction

   function automatic logic [1:0] model_start(input int unsigned x, input int unsigned y,
                                              input int unsigned gw, input int unsigned gh);
      int unsigned part, ms;
      armed = 1'b0;
      if (gw + x >= scr_w || gw > MAX_GLYPH) return STATUS_TOO_WIDE;
      if (gh + y >= scr_h || gh > MAX_GLYPH) return STATUS_TOO_TALL;
      if (gw == 0 || gh == 0) return STATUS_OK;
      shift_amt  = x & 7;
      row_bytes  = gw / 8;
      right_fill = 0;
      spills     = 1'b0;
      part       = gw & 7;
      if (part != 0) begin
         ms = part + shift_amt;
         if (ms > 8) begin
            ms     = ms - 8;
            spills = 1'b1;
         end
         right_fill = (ms < 8) ? (32'hFF >> ms) : 0;
         row_bytes++;
      end else if (shift_amt != 0) begin
         // whole-byte width with a shift: carried bits land in one extra byte
         spills     = 1'b1;
         right_fill = 32'hFF >> shift_amt;
      end
      cur_row    = wrap_store(x / 8 + y * (scr_w / 8));
      carry      = dest_keep_mask() & pix_store[cur_row];
      col_idx    = 0;
      rows_to_go = gh;
      armed      = 1'b1;
      return STATUS_OK;
   endfunction

   function automatic void model_glyph_byte(input int unsigned b);
      int unsigned a;
      if (!armed) return;
      a = wrap_store(cur_row + col_idx);
      if (shift_amt == 0) begin
         pix_store[a] = 8'(b);
      end else begin
         pix_store[a] = 8'((b >> shift_amt) | carry);
         carry        = (b << (8 - shift_amt)) & 32'hFF;
      end
      if (col_idx + 1 >= row_bytes) begin
         // close the row, then step to the next one
         if (spills) pix_store[wrap_store(a + 1)] = 8'(carry | right_fill);
         else        pix_store[a] = pix_store[a] | 8'(right_fill);
         cur_row    = wrap_store(cur_row + scr_w / 8);
         carry      = dest_keep_mask() & pix_store[cur_row];
         col_idx    = 0;
         rows_to_go = rows_to_go - 1;
         if (rows_to_go == 0) armed = 1'b0;
      end else begin
         col_idx++;
      end
   endfunction

   // Returns 0 for a glyph byte that the idle blitter drops
   function automatic bit blit_model_step(input blit_req_type it, output blit_rsp_type r);
      bit counts;
      counts      = 1'b1;
      r.status    = STATUS_OK;
      r.read_data = 8'h00;
      case (it.kind)
         KIND_CLEAR: fill_white();
         KIND_START: r.status = model_start(it.pos_x, it.pos_y, it.glyph_width,
                                            it.glyph_height);
         KIND_GLYPH: begin
            counts = armed;
            model_glyph_byte(it.glyph_byte);
         end
         default: r.read_data = pix_store[it.read_address];
      endcase
      return counts;
   endfunction

   // ------------------------------------------------------------------
   // Item builders: unused fields carry random values
   // ------------------------------------------------------------------
   function automatic blit_req_type random_fields();
      blit_req_type it;
      it.kind         = 2'($urandom_range(3, 0));
      it.pos_x        = 9'($urandom);
      it.pos_y        = 8'($urandom);
      it.glyph_width  = 7'($urandom);
      it.glyph_height = 7'($urandom);
      it.glyph_byte   = 8'($urandom);
      it.read_address = 14'($urandom);
      return it;
   endfunction

   function automatic blit_req_type mk_start(input int unsigned x, input int unsigned y,
                                             input int unsigned gw, input int unsigned gh);
      blit_req_type it;
      it              = random_fields();
      it.kind         = KIND_START;
      it.pos_x        = 9'(x);
      it.pos_y        = 8'(y);
      it.glyph_width  = 7'(gw);
      it.glyph_height = 7'(gh);
      return it;
   endfunction

   function automatic blit_req_type mk_byte(input int unsigned b);
      blit_req_type it;
      it            = random_fields();
      it.kind       = KIND_GLYPH;
      it.glyph_byte = 8'(b);
      return it;
   endfunction

   function automatic blit_req_type mk_read(input int unsigned a);
      blit_req_type it;
      it              = random_fields();
      it.kind         = KIND_READ;
      it.read_address = 14'(a);
      return it;
   endfunction

   function automatic blit_req_type mk_clear();
      blit_req_type it;
      it      = random_fields();
      it.kind = KIND_CLEAR;
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------
   // Present one item after a random gap, hold it until the transfer
   task automatic push_blit_item(input blit_req_type it);
      blit_rsp_type want;
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= it.kind;
      req_pos_x        <= it.pos_x;
      req_pos_y        <= it.pos_y;
      req_glyph_width  <= it.glyph_width;
      req_glyph_height <= it.glyph_height;
      req_glyph_byte   <= it.glyph_byte;
      req_read_address <= it.read_address;
      do @(posedge clock); while (req_stall);
      if (blit_model_step(it, want)) blit_items_done++;
      blit_result_q.push_back(want);
   endtask

   // Drop valid, wait for every result, then let the block settle
   task automatic wait_blit_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (blit_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_screen_reg(input logic [1:0] idx, input logic [9:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SCREEN_WIDTH:  scr_w = val;
         REG_SCREEN_HEIGHT: scr_h = val & 10'h1FF;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random result back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < rsp_stall_pct);
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : result_check
      blit_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blit_result_q.size() == 0) begin
            $display("%0t: result with none pending, expected nothing, got status %0d data %h",
                     $time, rsp_status, rsp_read_data);
            mismatch_count++;
         end else begin
            want = blit_result_q.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data mismatch, expected %h, got %h",
                        $time, want.read_data, rsp_read_data);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Store comes out of reset white at both ends
   task automatic test_reset_state();
      push_blit_item(mk_read(0));
      push_blit_item(mk_read(STORE_BYTES - 1));
   endtask

   // Width check before height, size limits, empty glyphs
   task automatic test_start_checks();
      push_blit_item(mk_start(511, 0, 1, 1));
      push_blit_item(mk_start(0, 255, 1, 1));
      push_blit_item(mk_start(0, 0, 127, 1));
      push_blit_item(mk_start(0, 0, 1, 127));
      push_blit_item(mk_start(0, 0, 0, 5));
      push_blit_item(mk_byte(8'h00));
      push_blit_item(mk_start(0, 0, 3, 0));
   endtask

   task automatic test_glyph_cases();
      // whole-byte width with a shift spills into a third byte
      push_blit_item(mk_start(3, 2, 16, 1));
      push_blit_item(mk_byte(8'hA5));
      push_blit_item(mk_byte(8'h0F));
      push_blit_item(mk_read(66));
      push_blit_item(mk_read(67));
      push_blit_item(mk_read(68));
      // restart while armed, glyph end, then a stray byte
      push_blit_item(mk_start(8, 0, 9, 2));
      push_blit_item(mk_byte(8'h00));
      push_blit_item(mk_start(0, 1, 8, 1));
      push_blit_item(mk_byte(8'h55));
      push_blit_item(mk_byte(8'hFF));
      push_blit_item(mk_read(33));
      // clear in the middle of an armed glyph
      push_blit_item(mk_start(1, 3, 4, 2));
      push_blit_item(mk_byte(8'h00));
      push_blit_item(mk_clear());
      push_blit_item(mk_byte(8'h00));
      push_blit_item(mk_read(132));
      // failed start disarms the glyph in progress
      push_blit_item(mk_start(0, 0, 8, 2));
      push_blit_item(mk_start(263, 0, 1, 1));
      push_blit_item(mk_byte(8'h00));
      push_blit_item(mk_read(0));
   endtask

   // Smallest screen, unused indexes, masked height, odd width
   task automatic test_screen_limits();
      wait_blit_drain();
      write_screen_reg(REG_SCREEN_WIDTH, 10'd8);
      write_screen_reg(REG_SCREEN_HEIGHT, 10'd1);
      push_blit_item(mk_start(0, 0, 7, 0));
      push_blit_item(mk_start(0, 0, 1, 1));
      wait_blit_drain();
      write_screen_reg(REG_UNUSED_2, 10'h3FF);
      write_screen_reg(REG_UNUSED_3, 10'h155);
      write_screen_reg(REG_SCREEN_WIDTH, 10'h1FF);
      write_screen_reg(REG_SCREEN_HEIGHT, 10'h2A5);
      push_blit_item(mk_start(502, 163, 8, 1));
      push_blit_item(mk_byte(8'h3C));
      push_blit_item(mk_read(62 + 163 * 63));
      push_blit_item(mk_read(63 + 163 * 63));
   endtask

   // Well-formed glyph with random content, optionally cut short, then read back
   task automatic blit_random_glyph(input bit cut_short);
      int unsigned gw, gh, x, y, bpr, total, sent, k, r, a;
      int          c;
      gw = ($urandom_range(9, 0) < 8) ? $urandom_range(24, 1) : $urandom_range(MAX_GLYPH, 25);
      gh = ($urandom_range(19, 0) < 17) ? $urandom_range(6, 1) : $urandom_range(MAX_GLYPH, 7);
      if (gw > scr_w - 1) gw = scr_w - 1;
      if (scr_h < 2) begin
         push_blit_item(mk_start($urandom_range(scr_w - gw - 1, 0), 0, gw, 1));
         return;
      end
      if (gh > scr_h - 1) gh = scr_h - 1;
      x     = $urandom_range(scr_w - gw - 1, 0);
      y     = $urandom_range(scr_h - gh - 1, 0);
      bpr   = (gw + 7) / 8;
      total = bpr * gh;
      sent  = cut_short ? $urandom_range(total - 1, 0) : total;
      push_blit_item(mk_start(x, y, gw, gh));
      for (k = 0; k < sent; k++) begin
         if ($urandom_range(3, 0) == 0) push_blit_item(mk_byte({8{$urandom_range(1, 0) == 1}}));
         else                           push_blit_item(mk_byte($urandom));
      end
      if (!cut_short && $urandom_range(7, 0) == 0) push_blit_item(mk_byte($urandom));
      // sample the glyph box and one byte either side
      for (k = 0; k < 4; k++) begin
         r = $urandom_range(gh - 1, 0);
         c = int'($urandom_range(bpr + 1, 0)) - 1;
         a = (x / 8 + (y + r) * (scr_w / 8) + c + STORE_BYTES) % STORE_BYTES;
         push_blit_item(mk_read(a));
      end
   endtask

   task automatic run_traffic_segment(input int unsigned w, input int unsigned h,
                                      input int idle_pct, input int stall_pct, input int goal);
      int           first;
      int           r;
      blit_req_type it;
      wait_blit_drain();
      write_screen_reg(REG_SCREEN_WIDTH, 10'(w));
      write_screen_reg(REG_SCREEN_HEIGHT, 10'(h));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first         = blit_items_done;
      while (blit_items_done - first < goal) begin
         r = $urandom_range(99, 0);
         if (r < 70) begin
            blit_random_glyph(1'b0);
         end else if (r < 80) begin
            blit_random_glyph(1'b1);
         end else if (r < 96) begin
            it = random_fields();
            if (it.kind == KIND_CLEAR) it.kind = KIND_READ;
            push_blit_item(it);
         end else if (r < 98) begin
            // hold off the sender until the block is empty
            wait_blit_drain();
         end else if (clears_left > 0) begin
            clears_left--;
            push_blit_item(mk_clear());
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_segment(264, 176, 24, 57, 300);
      run_traffic_segment(512, 256, 24, 57, 300);
      run_traffic_segment(8, 256, 57, 24, 250);
      run_traffic_segment(512, 1, 57, 24, 60);
      run_traffic_segment(136, 64, 0, 0, 300);
      run_traffic_segment(100, 37, 0, 0, 300);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      model_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      rsp_stall_pct = 57;
      test_reset_state();
      test_start_checks();
      test_glyph_cases();
      test_screen_limits();
      test_random_traffic();
      wait_blit_drain();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

// File: mono_glyph_bit_blitter_unit.f
rtl/core/mgbb_pkg.sv
rtl/core/mgbb_glyph_setup.sv
rtl/core/mono_glyph_bit_blitter_unit.sv
tb/tb_mono_glyph_bit_blitter_unit.sv
